// ----- hdl/vsrx_pkg.sv -----
// vsrx_pkg: constants, types and the sync pattern for the voice stream receive filter.
// No dependencies; imported by vsrx_check and voice_stream_rx_filter.
package vsrx_pkg;

  localparam int STORE_BYTES  = 64;
  localparam int HEADER_BYTES = 41;
  localparam int FRAME_BYTES  = 12;
  localparam int PAYLOAD_AT   = 15;

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int IDX_W  = $clog2(HEADER_BYTES);

  localparam int MIN_PACKET = PAYLOAD_AT;
  localparam int MIN_HEADER = PAYLOAD_AT + HEADER_BYTES;
  localparam int MIN_FRAME  = PAYLOAD_AT + FRAME_BYTES;

  localparam int SYNC_FIRST = 9;
  localparam int SYNC_MID   = 10;

  localparam logic [7:0] SEQ_HEADER = 8'h80;
  localparam logic [7:0] SEQ_END    = 8'h40;
  localparam logic [7:0] SEQ_MASK   = 8'h1F;

  localparam logic [7:0] CHR_D = 8'h44;
  localparam logic [7:0] CHR_S = 8'h53;
  localparam logic [7:0] CHR_V = 8'h56;
  localparam logic [7:0] CHR_T = 8'h54;

  localparam logic [6:0] LETTER_A = 7'h41;
  localparam logic [6:0] LETTER_B = 7'h42;
  localparam logic [6:0] LETTER_C = 7'h43;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  localparam logic RUN_HEADER = 1'b0;
  localparam logic RUN_FRAME  = 1'b1;

  typedef struct packed {
    logic take;
    logic frame;
    logic sync;
    logic stream_end;
  } verdict_t;

  function automatic logic [7:0] sync_byte(input logic [IDX_W-1:0] i);
    logic [7:0] b;
    case (i)
      IDX_W'(SYNC_FIRST): b = 8'h55;
      IDX_W'(SYNC_MID):   b = 8'h2D;
      default:            b = 8'h16;
    endcase
    return b;
  endfunction

endpackage

// ----- hdl/vsrx_check.sv -----
// vsrx_check: captures the check bytes of a packet, holds the open stream id
// and decides at the closing beat whether a header or frame is taken. Uses vsrx_pkg.
module vsrx_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              beat,
  input  logic              kind,
  input  logic [7:0]        rx_byte,
  input  logic              packet_last,
  input  logic [7:0]        byte_count,
  input  logic [6:0]        module_letter,
  output vsrx_pkg::verdict_t verdict
);
  import vsrx_pkg::*;

  logic [7:0]  b0, b1, b2, b3, b12, b13, b14, b25;
  logic [7:0]  c0, c1, c2, c3, c12, c13, c14, c25;
  logic        stream_open;
  logic [15:0] open_id;
  logic        closing;
  logic [8:0]  len;
  logic        base_ok, hdr_ok, frm_ok, is_hdr;

  always_comb begin
    c0  = (byte_count == 8'd0)  ? rx_byte : b0;
    c1  = (byte_count == 8'd1)  ? rx_byte : b1;
    c2  = (byte_count == 8'd2)  ? rx_byte : b2;
    c3  = (byte_count == 8'd3)  ? rx_byte : b3;
    c12 = (byte_count == 8'd12) ? rx_byte : b12;
    c13 = (byte_count == 8'd13) ? rx_byte : b13;
    c14 = (byte_count == 8'd14) ? rx_byte : b14;
    c25 = (byte_count == 8'd25) ? rx_byte : b25;
    len = 9'(byte_count) + 9'd1;
    closing = beat && (kind == KIND_BYTE) && packet_last;
    base_ok = (len >= 9'(MIN_PACKET)) && (c0 == CHR_D) && (c1 == CHR_S) &&
              (c2 == CHR_V) && (c3 == CHR_T);
    is_hdr  = (c14 == SEQ_HEADER);
    hdr_ok  = !stream_open && (len >= 9'(MIN_HEADER)) && (c25 == {1'b0, module_letter});
    frm_ok  = stream_open && ({c13, c12} == open_id) && (len >= 9'(MIN_FRAME));
    verdict.take       = closing && base_ok && (is_hdr ? hdr_ok : frm_ok);
    verdict.frame      = is_hdr ? RUN_HEADER : RUN_FRAME;
    verdict.sync       = !is_hdr && ((c14 & SEQ_MASK) == 8'h00);
    verdict.stream_end = !is_hdr && ((c14 & SEQ_END) != 8'h00);
  end

  always_ff @(posedge clk) begin
    if (beat && (kind == KIND_BYTE)) begin
      b0  <= c0;
      b1  <= c1;
      b2  <= c2;
      b3  <= c3;
      b12 <= c12;
      b13 <= c13;
      b14 <= c14;
      b25 <= c25;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_open <= 1'b0;
      open_id     <= 16'h0000;
    end else if (beat && (kind == KIND_CLOSE)) begin
      stream_open <= 1'b0;
      open_id     <= 16'h0000;
    end else if (verdict.take) begin
      if (verdict.frame == RUN_HEADER) begin
        stream_open <= 1'b1;
        open_id     <= {c13, c12};
      end else if (verdict.stream_end) begin
        stream_open <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/voice_stream_rx_filter.sv -----
// voice_stream_rx_filter: top level; packet store memory, emit sequencer, output register.
// Uses vsrx_pkg and vsrx_check.
// The first result beat follows the closing byte through S_READ, rd_data and out_byte.
// Throughput: one input byte per cycle while idle; during a run of 41 or 12 beats
// (one per cycle unless stalled) input stalls while the emit sequencer is not idle.
// Reset: stream closed, byte count zero, module letter C; the packet store is not cleared.
module voice_stream_rx_filter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] rx_byte,
  input  logic       packet_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       frame_kind,
  output logic       run_last,
  output logic       sync_frame,
  output logic       stream_end,
  input  logic       cfg_write,
  input  logic [6:0] cfg_data
);
  import vsrx_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t             state;
  logic [6:0]         module_letter;
  logic [7:0]         byte_count;
  logic               beat;
  verdict_t           verdict;
  logic [7:0]         mem [STORE_BYTES];
  logic [7:0]         rd_data;
  logic               wr_en, rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [IDX_W-1:0]   idx, last_idx;
  logic               run_frame, run_sync, run_end;
  logic               slot_free, load, load_last;

  assign in_stall = (state != S_IDLE);
  assign beat     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_letter <= LETTER_C;
    end else if (cfg_write) begin
      if ((cfg_data == LETTER_A) || (cfg_data == LETTER_B) || (cfg_data == LETTER_C)) begin
        module_letter <= cfg_data;
      end else begin
        module_letter <= LETTER_B;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= 8'd0;
    end else if (beat && (kind == KIND_BYTE)) begin
      if (packet_last) begin
        byte_count <= 8'd0;
      end else if (byte_count != 8'hFF) begin
        byte_count <= byte_count + 8'd1;
      end
    end
  end

  vsrx_check u_check (
    .clk           (clk),
    .rst           (rst),
    .beat          (beat),
    .kind          (kind),
    .rx_byte       (rx_byte),
    .packet_last   (packet_last),
    .byte_count    (byte_count),
    .module_letter (module_letter),
    .verdict       (verdict)
  );

  assign slot_free = !out_valid || !out_stall;
  assign load      = (state == S_LOAD) && slot_free;
  assign load_last = load && (idx == last_idx);
  assign wr_en     = beat && (kind == KIND_BYTE) && (9'(byte_count) < 9'(STORE_BYTES));
  assign rd_en     = (state == S_READ) || (load && !load_last);
  assign rd_addr   = ADDR_W'(PAYLOAD_AT) + ADDR_W'(idx) + ADDR_W'(state == S_LOAD);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[byte_count[ADDR_W-1:0]] <= rx_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (verdict.take) begin
            state     <= S_READ;
            idx       <= '0;
            run_frame <= verdict.frame;
            run_sync  <= verdict.sync;
            run_end   <= verdict.stream_end;
            last_idx  <= (verdict.frame == RUN_FRAME) ? IDX_W'(FRAME_BYTES - 1)
                                                      : IDX_W'(HEADER_BYTES - 1);
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (load_last) begin
            state <= S_IDLE;
          end else if (load) begin
            idx <= idx + IDX_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= (run_sync && (idx >= IDX_W'(SYNC_FIRST))) ? sync_byte(idx) : rd_data;
      frame_kind <= run_frame;
      run_last   <= (idx == last_idx);
      sync_frame <= run_sync;
      stream_end <= run_end;
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !rd_en)
    else $error("store written and read in the same cycle");

  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && !slot_free) |=> $stable(rd_data))
    else $error("read data changed while waiting for output slot");

  a_run_done: assert property (@(posedge clk) disable iff (rst)
    load_last |=> (state == S_IDLE) && out_valid && run_last)
    else $error("run did not end on its last beat");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    verdict.take |-> (state == S_IDLE))
    else $error("packet taken while a run is active");

endmodule

// ----- verif/voice_stream_rx_filter_tb.sv -----
// voice_stream_rx_filter_tb: self-checking bench for the voice stream receive filter.
// Drives datagram beats and module letter writes, predicts header and frame runs, checks outputs.
// Depends on vsrx_pkg and the voice_stream_rx_filter RTL.
module voice_stream_rx_filter_tb;
  import vsrx_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run;
    logic       last;
    logic       sync;
    logic       closes;
  } out_beat_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       kind;
  logic [7:0] rx_byte;
  logic       packet_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       frame_kind;
  logic       run_last;
  logic       sync_frame;
  logic       stream_end;
  logic       cfg_write;
  logic [6:0] cfg_data;

  voice_stream_rx_filter dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .rx_byte(rx_byte),
    .packet_last(packet_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .frame_kind(frame_kind),
    .run_last(run_last),
    .sync_frame(sync_frame),
    .stream_end(stream_end),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  // shadow of the filter state
  logic [7:0]  shadow_store [STORE_BYTES];
  logic [7:0]  shadow_count = '0;
  logic        chan_open    = 1'b0;
  logic [15:0] chan_id      = '0;
  logic [6:0]  chan_letter  = LETTER_C;

  out_beat_t   beats_due[$];
  rx_item_t    rx_items_q[$];
  logic [7:0]  pkt_bytes[$];

  int   fails      = 0;
  int   items_made = 0;
  int   in_wait    = 0;
  int   stall_left = 0;
  logic in_took    = 1'b0;
  logic in_calm    = 1'b0;
  logic out_calm   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    kind        = KIND_BYTE;
    rx_byte     = '0;
    packet_last = 1'b0;
    out_stall   = 1'b0;
    cfg_write   = 1'b0;
    cfg_data    = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_beat(logic [7:0] b, logic run, logic last, logic sync, logic closes);
    out_beat_t e;
    e = '{data: b, run: run, last: last, sync: sync, closes: closes};
    beats_due.push_back(e);
  endtask

  task automatic judge_packet(int plen);
    logic [15:0] sid;
    logic [7:0]  seq;
    logic [7:0]  b;
    logic        sync;
    logic        closes;
    if (plen < MIN_PACKET) return;
    if (shadow_store[0] != CHR_D || shadow_store[1] != CHR_S ||
        shadow_store[2] != CHR_V || shadow_store[3] != CHR_T) return;
    sid = {shadow_store[13], shadow_store[12]};
    seq = shadow_store[14];
    if (seq == SEQ_HEADER) begin
      if (chan_open || plen < MIN_HEADER) return;
      if (shadow_store[25] != {1'b0, chan_letter}) return;
      chan_open = 1'b1;
      chan_id   = sid;
      for (int i = 0; i < HEADER_BYTES; i++)
        push_beat(shadow_store[PAYLOAD_AT + i], RUN_HEADER, i == HEADER_BYTES - 1, 1'b0, 1'b0);
      return;
    end
    if (!chan_open || sid != chan_id) return;
    if (plen < MIN_FRAME) return;
    sync   = (seq & SEQ_MASK) == 8'h00;
    closes = (seq & SEQ_END) != 8'h00;
    if (closes) chan_open = 1'b0;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      b = shadow_store[PAYLOAD_AT + i];
      if (sync) begin
        case (i)
          SYNC_FIRST:     b = 8'h55;
          SYNC_FIRST + 1: b = 8'h2D;
          SYNC_FIRST + 2: b = 8'h16;
          default:        ;
        endcase
      end
      push_beat(b, RUN_FRAME, i == FRAME_BYTES - 1, sync, closes);
    end
  endtask

  task automatic absorb_byte(rx_item_t it);
    int plen;
    if (it.kind == KIND_CLOSE) begin
      chan_open = 1'b0;
      chan_id   = '0;
      return;
    end
    if (shadow_count < STORE_BYTES) shadow_store[shadow_count] = it.data;
    plen = shadow_count + 1;
    if (shadow_count != 8'hFF) shadow_count = shadow_count + 8'd1;
    if (!it.last) return;
    shadow_count = '0;
    judge_packet(plen);
  endtask

  task automatic note_letter(logic [6:0] v);
    if (v == LETTER_A || v == LETTER_B || v == LETTER_C) chan_letter = v;
    else chan_letter = LETTER_B;
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  // input beat driver
  always @(negedge clk) begin : drive_rx
    rx_item_t nx;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_wait > 0) begin
        in_wait  <= in_wait - 1;
        in_valid <= 1'b0;
      end else if (rx_items_q.size() > 0) begin
        nx          = rx_items_q.pop_front();
        kind        <= nx.kind;
        rx_byte     <= nx.data;
        packet_last <= nx.last;
        in_valid    <= 1'b1;
        in_wait     <= in_calm ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall pattern
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!out_calm && $urandom_range(0, 99) < 30) stall_left <= pick_gap();
    end
  end

  // monitor: accepted input beats, register writes, result beats
  always @(posedge clk) begin : watch
    rx_item_t  it;
    out_beat_t e;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        it = '{kind: kind, data: rx_byte, last: packet_last};
        absorb_byte(it);
      end
      if (cfg_write) note_letter(cfg_data);
      if (out_valid && !out_stall) begin
        if (beats_due.size() == 0) begin
          $error("unexpected result beat: out_byte %0h", out_byte);
          fails++;
        end else begin
          e = beats_due.pop_front();
          check_field("out_byte", e.data, out_byte);
          check_field("frame_kind", 8'(e.run), 8'(frame_kind));
          check_field("run_last", 8'(e.last), 8'(run_last));
          check_field("sync_frame", 8'(e.sync), 8'(sync_frame));
          check_field("stream_end", 8'(e.closes), 8'(stream_end));
        end
      end
    end
  end

  task automatic build_dsvt(logic [7:0] seq, logic [15:0] sid, int len, logic [6:0] letter,
                            int fill);
    logic [7:0] b;
    pkt_bytes.delete();
    for (int i = 0; i < len; i++) begin
      case (i)
        0:       b = CHR_D;
        1:       b = CHR_S;
        2:       b = CHR_V;
        3:       b = CHR_T;
        12:      b = sid[7:0];
        13:      b = sid[15:8];
        14:      b = seq;
        default: b = (fill < 0) ? 8'($urandom) : 8'(fill);
      endcase
      if (i == 25 && seq == SEQ_HEADER) b = {1'b0, letter};
      pkt_bytes.push_back(b);
    end
  endtask

  task automatic queue_close();
    rx_item_t it;
    it = '{kind: KIND_CLOSE, data: 8'($urandom), last: 1'($urandom)};
    rx_items_q.push_back(it);
    items_made++;
  endtask

  // close_at >= 0 slips a close item in before that byte
  task automatic queue_packet(int close_at);
    rx_item_t it;
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      if (i == close_at) queue_close();
      it = '{kind: KIND_BYTE, data: pkt_bytes[i], last: i == pkt_bytes.size() - 1};
      rx_items_q.push_back(it);
      items_made++;
    end
  endtask

  task automatic send_dsvt(logic [7:0] seq, logic [15:0] sid, int len, logic [6:0] letter,
                           int fill);
    build_dsvt(seq, sid, len, letter, fill);
    queue_packet(-1);
  endtask

  task automatic wait_quiet();
    while (rx_items_q.size() != 0 || in_valid || beats_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_letter(logic [6:0] v);
    wait_quiet();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_traffic(int budget);
    int          stop_at;
    int          r;
    int          nf;
    int          seqn;
    int          len;
    logic [15:0] sid;
    logic [7:0]  seq;
    logic [6:0]  letter;
    in_calm  = ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
    stop_at  = items_made + budget;
    while (items_made < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        queue_close();
      end else if (r < 12) begin
        pkt_bytes.delete();
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) pkt_bytes.push_back(8'($urandom));
        queue_packet(-1);
      end else begin
        sid = $urandom_range(0, 9) == 0 ? 16'h0000 : 16'($urandom);
        letter = chan_letter;
        if ($urandom_range(0, 9) == 0) letter = 7'(LETTER_A + $urandom_range(0, 2));
        r = $urandom_range(0, 19);
        len = (r == 0) ? $urandom_range(MIN_PACKET, MIN_HEADER - 1) :
              (r == 1) ? $urandom_range(MIN_HEADER + 1, 80) : MIN_HEADER;
        send_dsvt(SEQ_HEADER, sid, len, letter, -1);
        nf   = $urandom_range(1, 4);
        seqn = $urandom_range(0, 20);
        for (int f = 0; f < nf; f++) begin
          seq  = 8'(seqn);
          seqn = (seqn + 1) % 21;
          if (f == nf - 1 && $urandom_range(0, 3) != 0) seq = seq | SEQ_END;
          if ($urandom_range(0, 15) == 0) seq = seq | SEQ_HEADER;
          r = $urandom_range(0, 19);
          len = (r == 0) ? $urandom_range(MIN_PACKET, MIN_FRAME - 1) :
                (r == 1) ? $urandom_range(MIN_FRAME + 1, 70) : MIN_FRAME;
          build_dsvt(seq, ($urandom_range(0, 14) == 0) ? sid ^ 16'h0100 : sid, len,
                     chan_letter, -1);
          queue_packet(($urandom_range(0, 24) == 0) ? $urandom_range(0, len - 1) : -1);
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] id1;
    id1 = 16'hA5C3;
    @(negedge clk);
    while (rst) @(negedge clk);

    // directed, module letter at reset value
    send_dsvt(SEQ_HEADER, id1, 257, LETTER_C, -1);      // count saturates, store overflows
    send_dsvt(8'h00, id1, MIN_FRAME, LETTER_C, 8'hFF);  // sync frame
    send_dsvt(8'h03, id1, MIN_FRAME - 1, LETTER_C, -1);
    build_dsvt(8'h06, id1, MIN_FRAME, LETTER_C, -1);
    queue_packet(20);                                   // close mid-packet

    write_letter(7'h7F);
    random_traffic(60);

    wait_quiet();
    repeat (30) @(negedge clk);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/vsrx_pkg.sv
hdl/vsrx_check.sv
hdl/voice_stream_rx_filter.sv
verif/voice_stream_rx_filter_tb.sv
